FILE: hw/rtl/isd_pkg.sv
package isd_pkg;

  localparam int AXIS_W = 32;
  localparam int ABS_W  = 31;
  localparam int MAG_W  = 32;
  localparam int ACC_W  = 64;
  localparam int STAT_W = 25;
  localparam int CFG_AW = 2;

  localparam int MIN_SAMPLES = 5;

  localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

  localparam logic [CFG_AW-1:0] REG_MAX_ACCEL_SPREAD = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_GYRO_SPREAD  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_GYRO_MIDDLE  = 2'd2;

  localparam logic [STAT_W-1:0] RST_MAX_ACCEL_SPREAD = 25'd6554;
  localparam logic [STAT_W-1:0] RST_MAX_GYRO_SPREAD  = 25'd655;
  localparam logic [STAT_W-1:0] RST_MAX_GYRO_MIDDLE  = 25'd655;

  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;
    logic signed [AXIS_W-1:0] accel_offset_x;
    logic signed [AXIS_W-1:0] accel_offset_y;
    logic signed [AXIS_W-1:0] accel_offset_z;
    logic signed [AXIS_W-1:0] gyro_offset_x;
    logic signed [AXIS_W-1:0] gyro_offset_y;
    logic signed [AXIS_W-1:0] gyro_offset_z;
  } in_item_t;

  typedef struct packed {
    logic              stationary;
    logic [STAT_W-1:0] accel_spread;
    logic [STAT_W-1:0] gyro_spread;
    logic [STAT_W-1:0] gyro_middle;
  } out_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] max_accel_spread;
    logic [STAT_W-1:0] max_gyro_spread;
    logic [STAT_W-1:0] max_gyro_middle;
  } cfg_regs_t;

  // Absolute value of raw minus bias, clamped to the 31-bit axis range.
  function automatic logic [ABS_W-1:0] abs_sat_diff(input logic [AXIS_W-1:0] a,
                                                    input logic [AXIS_W-1:0] b);
    logic [AXIS_W:0] d;
    logic [AXIS_W:0] m;
    d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
    m = d[AXIS_W] ? (~d + 1'b1) : d;
    return (m[AXIS_W:ABS_W] != '0) ? {ABS_W{1'b1}} : m[ABS_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

  function automatic logic [STAT_W-1:0] sat_stat(input logic [MAG_W-1:0] v);
    return (v[MAG_W-1:STAT_W] != '0) ? STAT_MAX : v[STAT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/isd_sqrt.sv
module isd_sqrt import isd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] din,
  output logic             done,
  output logic [MAG_W-1:0] root
);

  // Two radicand bits per cycle, one root bit per cycle, rounds down.
  logic [ACC_W-1:0] x_r;
  logic [MAG_W+2:0] rem_r;
  logic [MAG_W-1:0] root_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [MAG_W+2:0] rem_sh;
  logic [MAG_W+2:0] trial;

  assign rem_sh = {rem_r[MAG_W:0], x_r[ACC_W-1:ACC_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= din;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r <= {x_r[ACC_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hw/rtl/isd_div.sv
module isd_div import isd_pkg::*; #(
  parameter int DW = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [ACC_W-1:0] quotient
);

  // Restoring division, one quotient bit per cycle.
  logic [ACC_W-1:0] q_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    d_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DW:0]      rsh;

  assign rsh = {rem_r, q_r[ACC_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      if (rsh >= {1'b0, d_r}) begin
        rem_r <= DW'(rsh - {1'b0, d_r});
        q_r   <= {q_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_r <= rsh[DW-1:0];
        q_r   <= {q_r[ACC_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/isd_front.sv
module isd_front import isd_pkg::*; #(
  parameter  int WINDOW = 20,
  localparam int CW     = $clog2(WINDOW + 1),
  localparam int SW     = $clog2(WINDOW)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  in_item_t      in_item,
  output logic          in_full,
  output logic          job_valid,
  output in_item_t      job_item,
  output logic [SW-1:0] job_slot,
  output logic [CW-1:0] job_n,
  output logic          job_short,
  input  logic          job_pop
);

  // Window bookkeeping happens here at accept time, so the back end only
  // sees finished jobs: slot to write, sample count, and the short flag.
  logic [CW-1:0] fill_r;
  logic [SW-1:0] wslot_r;
  logic [CW-1:0] n_new;
  logic          accept;

  in_item_t      q_item_r  [2];
  logic [SW-1:0] q_slot_r  [2];
  logic [CW-1:0] q_n_r     [2];
  logic          q_short_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;

  assign accept = in_push && !in_full;
  assign n_new  = (fill_r < CW'(WINDOW)) ? fill_r + CW'(1) : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      wslot_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        fill_r   <= n_new;
        wslot_r  <= (wslot_r == SW'(WINDOW - 1)) ? '0 : wslot_r + SW'(1);
        wr_ptr_r <= !wr_ptr_r;
      end
      if (job_pop && job_valid) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({accept, job_pop && job_valid})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_item_r[wr_ptr_r]  <= in_item;
      q_slot_r[wr_ptr_r]  <= wslot_r;
      q_n_r[wr_ptr_r]     <= n_new;
      q_short_r[wr_ptr_r] <= (n_new < CW'(MIN_SAMPLES));
    end
  end

  assign in_full   = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job_item  = q_item_r[rd_ptr_r];
  assign job_slot  = q_slot_r[rd_ptr_r];
  assign job_n     = q_n_r[rd_ptr_r];
  assign job_short = q_short_r[rd_ptr_r];

endmodule

FILE: hw/rtl/isd_back.sv
module isd_back import isd_pkg::*; #(
  parameter  int WINDOW = 20,
  localparam int CW     = $clog2(WINDOW + 1),
  localparam int SW     = $clog2(WINDOW),
  localparam int SUMW   = MAG_W + CW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  in_item_t      job_item,
  input  logic [SW-1:0] job_slot,
  input  logic [CW-1:0] job_n,
  input  logic          job_short,
  output logic          job_pop,
  input  cfg_regs_t     thr,
  input  logic          out_pop,
  output logic          out_empty,
  output out_item_t     out_item
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_WRITE = 15'b000000000000010,
    S_RD    = 15'b000000000000100,
    S_SQ    = 15'b000000000001000,
    S_ROOT  = 15'b000000000010000,
    S_MEANA = 15'b000000000100000,
    S_MEANG = 15'b000000001000000,
    S_VAR   = 15'b000000010000000,
    S_VDIVA = 15'b000000100000000,
    S_VDIVG = 15'b000001000000000,
    S_STD   = 15'b000010000000000,
    S_MI    = 15'b000100000000000,
    S_MCAP  = 15'b001000000000000,
    S_MCMP  = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  in_item_t      item_r;
  logic [SW-1:0] slot_r;
  logic [CW-1:0] n_r, i_r, j_r, lt_r, le_r;
  logic          short_r;
  logic [2:0]    step_r;
  logic          go_r;
  logic          cmp_v_r;
  logic [SW-1:0] i_idx;
  logic          last_i;

  logic [3*AXIS_W-1:0] arow_mem [WINDOW];
  logic [3*AXIS_W-1:0] grow_mem [WINDOW];
  logic [3*AXIS_W-1:0] arow_rd_r, grow_rd_r;
  logic [MAG_W-1:0]    am_mem [WINDOW];
  logic [MAG_W-1:0]    gm_mem [WINDOW];
  logic [MAG_W-1:0]    am_rd_r, gm_rd_r;
  logic [SW-1:0]       g_raddr;

  logic [ABS_W-1:0]   absd_a_r, absd_g_r;
  logic [MAG_W-1:0]   dev_a_r, dev_g_r;
  logic [2*ABS_W-1:0] sq_abs_a, sq_abs_g;
  logic [ACC_W-1:0]   sq_dev_a, sq_dev_g;
  logic [ACC_W-1:0]   prod_a_r, prod_g_r, acc_a_r, acc_g_r;
  logic [SUMW-1:0]    sum_a_r, sum_g_r;
  logic [MAG_W-1:0]   mean_a_r, mean_g_r, sd_a_r, sd_g_r;
  logic [ACC_W-1:0]   var_a_r, var_g_r;
  logic [MAG_W-1:0]   mi_r, lo_r, hi_r;
  logic [CW-1:0]      k_lo, k_hi;

  logic [AXIS_W-1:0] ax_a, ax_g, bs_a, bs_g;

  logic             sq_start;
  logic [ACC_W-1:0] sq_din_a, sq_din_g;
  logic             sq_done_a, sq_done_g;
  logic             sq_done;
  logic [MAG_W-1:0] root_a, root_g;

  logic             dv_start;
  logic [ACC_W-1:0] dv_dividend;
  logic             dv_done;
  logic [ACC_W-1:0] dv_q;

  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             fin_fire;
  logic [MAG_W:0]   mid_sum;
  logic [MAG_W-1:0] median;

  assign i_idx  = i_r[SW-1:0];
  assign last_i = (i_r == n_r - CW'(1));
  assign k_hi   = n_r >> 1;
  assign k_lo   = n_r[0] ? k_hi : k_hi - CW'(1);

  assign job_pop  = (state_r == S_IDLE) && job_valid;
  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || out_pop);

  // ---------------------------------------------------------------- units
  assign sq_start = go_r && ((state_r == S_ROOT) || (state_r == S_STD));
  assign sq_din_a = (state_r == S_STD) ? var_a_r : acc_a_r;
  assign sq_din_g = (state_r == S_STD) ? var_g_r : acc_g_r;

  isd_sqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .din(sq_din_a),
    .done(sq_done_a), .root(root_a)
  );

  isd_sqrt u_sqrt_g (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .din(sq_din_g),
    .done(sq_done_g), .root(root_g)
  );

  // Both roots start together and finish together.
  assign sq_done = sq_done_a && sq_done_g;

  assign dv_start = go_r && ((state_r == S_MEANA) || (state_r == S_MEANG) ||
                             (state_r == S_VDIVA) || (state_r == S_VDIVG));

  always_comb begin
    case (state_r)
      S_MEANA: dv_dividend = ACC_W'(sum_a_r);
      S_MEANG: dv_dividend = ACC_W'(sum_g_r);
      S_VDIVA: dv_dividend = acc_a_r;
      default: dv_dividend = acc_g_r;
    endcase
  end

  isd_div #(.DW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
    .divisor(n_r), .done(dv_done), .quotient(dv_q)
  );

  // ------------------------------------------------------------- memories
  always_comb begin
    case (state_r)
      S_MCAP:  g_raddr = '0;
      S_MCMP:  g_raddr = (j_r < n_r) ? j_r[SW-1:0] : '0;
      default: g_raddr = i_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      arow_mem[slot_r] <= {item_r.accel_x, item_r.accel_y, item_r.accel_z};
      grow_mem[slot_r] <= {item_r.gyro_x, item_r.gyro_y, item_r.gyro_z};
    end
    arow_rd_r <= arow_mem[i_idx];
    grow_rd_r <= grow_mem[i_idx];
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_ROOT) && sq_done) begin
      am_mem[i_idx] <= root_a;
      gm_mem[i_idx] <= root_g;
    end
    am_rd_r <= am_mem[i_idx];
    gm_rd_r <= gm_mem[g_raddr];
  end

  // ------------------------------------------------------------- datapath
  always_comb begin
    case (step_r[1:0])
      2'd0: begin
        ax_a = arow_rd_r[3*AXIS_W-1:2*AXIS_W];
        ax_g = grow_rd_r[3*AXIS_W-1:2*AXIS_W];
        bs_a = item_r.accel_offset_x;
        bs_g = item_r.gyro_offset_x;
      end
      2'd1: begin
        ax_a = arow_rd_r[2*AXIS_W-1:AXIS_W];
        ax_g = grow_rd_r[2*AXIS_W-1:AXIS_W];
        bs_a = item_r.accel_offset_y;
        bs_g = item_r.gyro_offset_y;
      end
      default: begin
        ax_a = arow_rd_r[AXIS_W-1:0];
        ax_g = grow_rd_r[AXIS_W-1:0];
        bs_a = item_r.accel_offset_z;
        bs_g = item_r.gyro_offset_z;
      end
    endcase
  end

  assign sq_abs_a = absd_a_r * absd_a_r;
  assign sq_abs_g = absd_g_r * absd_g_r;
  assign sq_dev_a = dev_a_r * dev_a_r;
  assign sq_dev_g = dev_g_r * dev_g_r;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign median  = mid_sum[MAG_W:1];

  always_ff @(posedge clk) begin
    go_r <= 1'b0;
    case (state_r)
      S_IDLE: begin
        item_r  <= job_item;
        slot_r  <= job_slot;
        n_r     <= job_n;
        short_r <= job_short;
      end
      S_WRITE: begin
        i_r     <= '0;
        sum_a_r <= '0;
        sum_g_r <= '0;
      end
      S_RD: begin
        step_r  <= '0;
        acc_a_r <= '0;
        acc_g_r <= '0;
      end
      S_SQ: begin
        if (step_r < 3'd3) begin
          absd_a_r <= abs_sat_diff(ax_a, bs_a);
          absd_g_r <= abs_sat_diff(ax_g, bs_g);
        end
        prod_a_r <= ACC_W'(sq_abs_a);
        prod_g_r <= ACC_W'(sq_abs_g);
        if (step_r >= 3'd2) begin
          acc_a_r <= sat_add(acc_a_r, prod_a_r);
          acc_g_r <= sat_add(acc_g_r, prod_g_r);
        end
        step_r <= step_r + 3'd1;
        if (step_r == 3'd4) begin
          go_r <= 1'b1;
        end
      end
      S_ROOT: begin
        if (sq_done) begin
          sum_a_r <= sum_a_r + SUMW'(root_a);
          sum_g_r <= sum_g_r + SUMW'(root_g);
          i_r     <= i_r + CW'(1);
          go_r    <= last_i;
        end
      end
      S_MEANA: begin
        if (dv_done) begin
          mean_a_r <= dv_q[MAG_W-1:0];
          go_r     <= 1'b1;
        end
      end
      S_MEANG: begin
        if (dv_done) begin
          mean_g_r <= dv_q[MAG_W-1:0];
          acc_a_r  <= '0;
          acc_g_r  <= '0;
          i_r      <= '0;
          step_r   <= '0;
        end
      end
      S_VAR: begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd1) begin
          dev_a_r <= (am_rd_r >= mean_a_r) ? am_rd_r - mean_a_r : mean_a_r - am_rd_r;
          dev_g_r <= (gm_rd_r >= mean_g_r) ? gm_rd_r - mean_g_r : mean_g_r - gm_rd_r;
        end
        if (step_r == 3'd2) begin
          prod_a_r <= sq_dev_a;
          prod_g_r <= sq_dev_g;
        end
        if (step_r == 3'd3) begin
          acc_a_r <= sat_add(acc_a_r, prod_a_r);
          acc_g_r <= sat_add(acc_g_r, prod_g_r);
          step_r  <= '0;
          i_r     <= i_r + CW'(1);
          go_r    <= last_i;
        end
      end
      S_VDIVA: begin
        if (dv_done) begin
          var_a_r <= dv_q;
          go_r    <= 1'b1;
        end
      end
      S_VDIVG: begin
        if (dv_done) begin
          var_g_r <= dv_q;
          go_r    <= 1'b1;
        end
      end
      S_STD: begin
        if (sq_done) begin
          sd_a_r <= root_a;
          sd_g_r <= root_g;
          i_r    <= '0;
        end
      end
      S_MCAP: begin
        mi_r    <= gm_rd_r;
        j_r     <= CW'(1);
        cmp_v_r <= 1'b1;
        lt_r    <= '0;
        le_r    <= '0;
      end
      S_MCMP: begin
        if (cmp_v_r) begin
          if (gm_rd_r < mi_r) begin
            lt_r <= lt_r + CW'(1);
          end
          if (gm_rd_r <= mi_r) begin
            le_r <= le_r + CW'(1);
          end
        end
        if (j_r < n_r) begin
          j_r     <= j_r + CW'(1);
          cmp_v_r <= 1'b1;
        end else begin
          cmp_v_r <= 1'b0;
        end
        if (!cmp_v_r) begin
          // Element i holds sorted ranks lt_r up to le_r - 1.
          if ((lt_r <= k_lo) && (k_lo < le_r)) begin
            lo_r <= mi_r;
          end
          if ((lt_r <= k_hi) && (k_hi < le_r)) begin
            hi_r <= mi_r;
          end
          i_r <= i_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (job_valid) state_nxt = S_WRITE;
      S_WRITE: state_nxt = short_r ? S_FIN : S_RD;
      S_RD:    state_nxt = S_SQ;
      S_SQ:    if (step_r == 3'd4) state_nxt = S_ROOT;
      S_ROOT:  if (sq_done) state_nxt = last_i ? S_MEANA : S_RD;
      S_MEANA: if (dv_done) state_nxt = S_MEANG;
      S_MEANG: if (dv_done) state_nxt = S_VAR;
      S_VAR:   if ((step_r == 3'd3) && last_i) state_nxt = S_VDIVA;
      S_VDIVA: if (dv_done) state_nxt = S_VDIVG;
      S_VDIVG: if (dv_done) state_nxt = S_STD;
      S_STD:   if (sq_done) state_nxt = S_MI;
      S_MI:    state_nxt = S_MCAP;
      S_MCAP:  state_nxt = S_MCMP;
      S_MCMP:  if (!cmp_v_r) state_nxt = last_i ? S_FIN : S_MI;
      S_FIN:   if (fin_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      if (short_r) begin
        out_item_r <= '0;
      end else begin
        out_item_r.stationary   <= (sd_a_r <= MAG_W'(thr.max_accel_spread)) &&
                                   (sd_g_r <= MAG_W'(thr.max_gyro_spread)) &&
                                   (median <= MAG_W'(thr.max_gyro_middle));
        out_item_r.accel_spread <= sat_stat(sd_a_r);
        out_item_r.gyro_spread  <= sat_stat(sd_g_r);
        out_item_r.gyro_middle  <= sat_stat(median);
      end
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hw/rtl/imu_stationarity_detector.sv
// Channel  | Direction | Ports                          | Handshake
// ---------+-----------+--------------------------------+-------------------------------
// input    | in        | in_push, in_full, in_item      | request taken on push && !full
// result   | out       | out_pop, out_empty, out_item   | request taken on pop && !empty
// config   | in        | cfg_we, cfg_addr, cfg_wdata    | written on every edge with we
//
// With fewer than five samples in the window, counting the new one, the result is all zeros.
// With n samples held an item needs a 32-step root per sample, a variance pass, four
// 64-step divisions, the spread roots and a rank-based median on one read port.
// Reset is synchronous, clears the window count and the queues and reloads the thresholds.
// Two requests wait in the front queue, one is worked on in the back end and one finished
// result waits in the output register; the input stalls whenever the front queue is full.

module imu_stationarity_detector import isd_pkg::*; #(
  parameter int WINDOW = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  in_item_t          in_item,
  output logic              in_full,
  output logic              out_empty,
  output out_item_t         out_item,
  input  logic              out_pop,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [STAT_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = $clog2(WINDOW);

  cfg_regs_t     thr_r;
  logic          job_valid;
  in_item_t      job_item;
  logic [SW-1:0] job_slot;
  logic [CW-1:0] job_n;
  logic          job_short;
  logic          job_pop;

  // Threshold registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.max_accel_spread <= RST_MAX_ACCEL_SPREAD;
      thr_r.max_gyro_spread  <= RST_MAX_GYRO_SPREAD;
      thr_r.max_gyro_middle  <= RST_MAX_GYRO_MIDDLE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_ACCEL_SPREAD: thr_r.max_accel_spread <= cfg_wdata;
        REG_MAX_GYRO_SPREAD:  thr_r.max_gyro_spread  <= cfg_wdata;
        REG_MAX_GYRO_MIDDLE:  thr_r.max_gyro_middle  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The front end tracks the window fill and write slot at accept time and
  // queues each request; the back end stores the sample and computes.
  isd_front #(.WINDOW(WINDOW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .job_valid (job_valid),
    .job_item  (job_item),
    .job_slot  (job_slot),
    .job_n     (job_n),
    .job_short (job_short),
    .job_pop   (job_pop)
  );

  isd_back #(.WINDOW(WINDOW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_item  (job_item),
    .job_slot  (job_slot),
    .job_n     (job_n),
    .job_short (job_short),
    .job_pop   (job_pop),
    .thr       (thr_r),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

FILE: hw/rtl/isd_checker.sv
module isd_checker import isd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input logic      out_pop,
  input logic      out_empty,
  input out_item_t out_item
);

  // Requests taken but whose result has not been popped yet.
  logic [3:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({in_push && !in_full, out_pop && !out_empty})
        2'b10:   pend_r <= pend_r + 4'd1;
        2'b01:   pend_r <= pend_r - 4'd1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result changed or vanished");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> pend_r != 4'd0)
    else $error("result shown without a pending request");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd4)
    else $error("more requests in flight than the design can hold");

endmodule

bind imu_stationarity_detector isd_checker u_isd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_item  (out_item)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the IMU stationarity detector.
// The sender pushes IMU samples through the input queue, a scoreboard process
// pops the results and compares them with the figures that a local model of
// the sliding window computes for each accepted sample.
module tb_top;
  import isd_pkg::*;

  localparam int WIN = 20;
  // Index that decodes to no register; writes to it must change nothing.
  localparam logic [CFG_AW-1:0] REG_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_item_t in_item = '0;
  logic in_full;
  logic out_empty;
  out_item_t out_item;
  logic out_pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [STAT_W-1:0] cfg_wdata = '0;

  imu_stationarity_detector #(.WINDOW(WIN)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_empty(out_empty), .out_item(out_item), .out_pop(out_pop),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the thresholds and of the raw sample window.
  logic [STAT_W-1:0] lim_accel_sd = RST_MAX_ACCEL_SPREAD;
  logic [STAT_W-1:0] lim_gyro_sd = RST_MAX_GYRO_SPREAD;
  logic [STAT_W-1:0] lim_gyro_md = RST_MAX_GYRO_MIDDLE;
  logic [31:0] win_accel [WIN][3];
  logic [31:0] win_gyro [WIN][3];
  int held = 0;
  int next_slot = 0;

  out_item_t stats_q[$];
  int fails = 0;
  bit calm = 1'b0;       // when set, neither side idles
  int stall_len = 0;     // receiver hold-off requested by a test, in cycles

  // Base sample of the current well-formed sequence of a still or moving unit.
  logic signed [31:0] base [6];
  logic signed [31:0] bias [6];
  int noise_amp = 0;

  function automatic longint unsigned isqrt_floor(longint unsigned x);
    longint unsigned root, t;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      t = root | (64'd1 << i);
      if (t * t <= x) root = t;
    end
    return root;
  endfunction

  // Square of |raw - bias|, with the difference clamped to 31 bits.
  function automatic longint unsigned axis_sq(logic signed [31:0] r, logic signed [31:0] b);
    longint d;
    longint unsigned a;
    d = longint'(r) - longint'(b);
    a = (d < 0) ? longint'(-d) : longint'(d);
    if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF;
    return a * a;
  endfunction

  function automatic longint unsigned vec_len(logic [31:0] s [3], logic signed [31:0] b0,
                                              logic signed [31:0] b1, logic signed [31:0] b2);
    return isqrt_floor(axis_sq(s[0], b0) + axis_sq(s[1], b1) + axis_sq(s[2], b2));
  endfunction

  function automatic longint unsigned std_dev(longint unsigned m [$]);
    longint unsigned sum, mean, acc, d, sq;
    sum = 0;
    acc = 0;
    foreach (m[i]) sum += m[i];
    mean = sum / m.size();
    foreach (m[i]) begin
      d = (m[i] >= mean) ? m[i] - mean : mean - m[i];
      sq = d * d;
      acc = (acc > ~64'd0 - sq) ? ~64'd0 : acc + sq;
    end
    return isqrt_floor(acc / m.size());
  endfunction

  function automatic logic [STAT_W-1:0] clamp_stat(longint unsigned v);
    return (v > STAT_MAX) ? STAT_MAX : v[STAT_W-1:0];
  endfunction

  // Stores the sample in the window and computes the three statistics.
  function automatic out_item_t window_stats(in_item_t it);
    out_item_t r;
    longint unsigned am [$], gm [$];
    longint unsigned a_sd, g_sd, g_md;
    int n;
    win_accel[next_slot] = '{it.accel_x, it.accel_y, it.accel_z};
    win_gyro[next_slot] = '{it.gyro_x, it.gyro_y, it.gyro_z};
    next_slot = (next_slot + 1) % WIN;
    if (held < WIN) held++;
    r = '0;
    if (held < MIN_SAMPLES) return r;
    for (int i = 0; i < held; i++) begin
      am.insert(am.size(), vec_len(win_accel[i], it.accel_offset_x, it.accel_offset_y,
                                   it.accel_offset_z));
      gm.insert(gm.size(), vec_len(win_gyro[i], it.gyro_offset_x, it.gyro_offset_y,
                                   it.gyro_offset_z));
    end
    a_sd = std_dev(am);
    g_sd = std_dev(gm);
    gm.sort();
    n = held;
    g_md = (n % 2 == 0) ? (gm[n/2-1] + gm[n/2]) >> 1 : gm[n/2];
    r.stationary = (a_sd <= lim_accel_sd) && (g_sd <= lim_gyro_sd) && (g_md <= lim_gyro_md);
    r.accel_spread = clamp_stat(a_sd);
    r.gyro_spread = clamp_stat(g_sd);
    r.gyro_middle = clamp_stat(g_md);
    return r;
  endfunction

  // Offers one request until the block takes it, then idles now and then.
  task automatic send_sample(in_item_t it);
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    stats_q.insert(stats_q.size(), window_stats(it));
    if (!calm && $urandom_range(99) < 7) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every expected result has been popped.
  task automatic drain();
    in_push <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [STAT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_ACCEL_SPREAD: lim_accel_sd = val;
      REG_MAX_GYRO_SPREAD: lim_gyro_sd = val;
      REG_MAX_GYRO_MIDDLE: lim_gyro_md = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [STAT_W-1:0] a, logic [STAT_W-1:0] g, logic [STAT_W-1:0] m);
    write_reg(REG_MAX_ACCEL_SPREAD, a);
    write_reg(REG_MAX_GYRO_SPREAD, g);
    write_reg(REG_MAX_GYRO_MIDDLE, m);
  endtask

  function automatic in_item_t noise_sample();
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return it;
  endfunction

  // Picks a new base for a sequence: a unit at rest near 1 g, a slowly
  // turning one, or a violently shaken one, with biases near the true values.
  task automatic new_sequence();
    int kind;
    kind = $urandom_range(3);
    for (int k = 0; k < 6; k++) begin
      base[k] = $signed($urandom_range(0, 20000)) - 10000;
      bias[k] = $signed($urandom_range(0, 400)) - 200;
    end
    base[2] = 32'sd642252;    // 9.8 m/s^2 on the z axis
    if (kind == 2) base[3] = 32'sd30000;
    case (kind)
      0: noise_amp = 0;
      1: noise_amp = 40;
      2: noise_amp = 1500;
      default: noise_amp = 200000;
    endcase
  endtask

  function automatic in_item_t seq_sample();
    in_item_t it;
    logic signed [31:0] v [12];
    for (int k = 0; k < 6; k++) begin
      v[k] = base[k] + $signed($urandom_range(0, 2 * noise_amp)) - noise_amp;
      v[6 + k] = bias[k] + $signed($urandom_range(0, 8)) - 4;
    end
    it = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
    return it;
  endfunction

  // Mostly well-formed sequences with random content, the rest pure noise.
  task automatic run_mix(int count);
    int left;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        new_sequence();
        left = $urandom_range(8, 40);
      end
      if ($urandom_range(99) < 20) send_sample(noise_sample());
      else begin
        send_sample(seq_sample());
        left--;
      end
    end
  endtask

  // The first four samples report zeros; then the corners of the field range,
  // including a raw minimum against a maximum bias so that the axis clamps.
  task automatic test_directed();
    in_item_t it;
    logic [31:0] corner [4];
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    for (int i = 0; i < 6; i++) send_sample('0);
    for (int i = 0; i < 4; i++) send_sample({12{corner[i]}});
    it = '0;
    {it.accel_x, it.accel_y, it.accel_z, it.gyro_x, it.gyro_y, it.gyro_z} = {6{32'h8000_0000}};
    {it.accel_offset_x, it.accel_offset_y, it.accel_offset_z} = {3{32'h7FFF_FFFF}};
    {it.gyro_offset_x, it.gyro_offset_y, it.gyro_offset_z} = {3{32'h7FFF_FFFF}};
    for (int i = 0; i < 3; i++) send_sample(it);
    for (int i = 0; i < 5; i++) send_sample(noise_sample());
    new_sequence();
    noise_amp = 0;
    for (int i = 0; i < 6; i++) send_sample(seq_sample());
    drain();
  endtask

  // Thresholds at both ends, and a write to the unused index that must not
  // disturb anything.
  task automatic test_limits();
    set_limits('0, '0, '0);
    run_mix(150);
    drain();
    set_limits(STAT_MAX, STAT_MAX, STAT_MAX);
    write_reg(REG_NONE, '0);
    run_mix(150);
    drain();
    set_limits(RST_MAX_ACCEL_SPREAD, RST_MAX_GYRO_SPREAD, RST_MAX_GYRO_MIDDLE);
  endtask

  // The receiver stops for a long time while samples keep coming, so the
  // block fills and holds its input off.
  task automatic test_backpressure();
    stall_len = 9000;
    run_mix(12);
    drain();
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      if (p > 0) set_limits(STAT_W'($urandom_range(0, 40000)), STAT_W'($urandom_range(0, 4000)),
                            STAT_W'($urandom_range(0, 40000)));
      calm = (p == 2);
      run_mix(240);
      drain();
    end
    calm = 1'b0;
  endtask

  // Result side: pops at random, honors a requested hold-off, and checks every
  // popped request against the oldest expectation.
  always @(posedge clk) begin
    if (stall_len > 0) begin
      stall_len <= stall_len - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= calm || ($urandom_range(99) >= 7);
    end
    if (rst_n && out_pop && !out_empty) begin
      if (stats_q.size() == 0) begin
        $error("result popped with nothing expected");
        fails++;
      end else begin
        out_item_t e;
        e = stats_q[0];
        stats_q.delete(0);
        if (out_item.stationary !== e.stationary) begin
          $error("stationary: expected %0d, got %0d", e.stationary, out_item.stationary);
          fails++;
        end
        if (out_item.accel_spread !== e.accel_spread) begin
          $error("accel_spread: expected %0d, got %0d", e.accel_spread, out_item.accel_spread);
          fails++;
        end
        if (out_item.gyro_spread !== e.gyro_spread) begin
          $error("gyro_spread: expected %0d, got %0d", e.gyro_spread, out_item.gyro_spread);
          fails++;
        end
        if (out_item.gyro_middle !== e.gyro_middle) begin
          $error("gyro_middle: expected %0d, got %0d", e.gyro_middle, out_item.gyro_middle);
          fails++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_backpressure();
    test_random();
    drain();
    repeat (2000) @(posedge clk);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // The time limit leaves wide margin even when every sample sees a full window.
  initial begin
    #60000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
